// File: design/ipid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Incremental PID speed loop - shared package
// Widths, reset values, register indexes and inter-stage types.
// ----------------------------------------------------------------------------
package ipid_pkg;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned DUTY_W  = 12;
  localparam int unsigned ERR_W   = SPEED_W + 1;  // target - measured
  localparam int unsigned D1_W    = ERR_W + 1;    // first difference
  localparam int unsigned D2_W    = ERR_W + 2;    // second difference
  localparam int unsigned PP_W    = GAIN_W + 1 + D1_W;
  localparam int unsigned PI_W    = GAIN_W + 1 + ERR_W;
  localparam int unsigned PD_W    = GAIN_W + 1 + D2_W;
  localparam int unsigned SUM_W   = PD_W + 2;
  localparam int unsigned Q_SHIFT = 8;            // Q8.8 gains
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned DSUM_W  = DUTY_W + 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned PWM_PERIOD_COUNT = 1000;

  localparam logic [DUTY_W-1:0] DUTY_RST    = DUTY_W'(PWM_PERIOD_COUNT / 2);
  localparam logic [GAIN_W-1:0] GAIN_P_RST  = GAIN_W'(128);
  localparam logic [GAIN_W-1:0] GAIN_I_RST  = GAIN_W'(20);
  localparam logic [GAIN_W-1:0] GAIN_D_RST  = GAIN_W'(0);
  localparam logic [DUTY_W-1:0] PWM_MIN_RST = DUTY_W'(50);
  localparam logic [DUTY_W-1:0] PWM_MAX_RST = DUTY_W'(950);

  localparam logic signed [STEP_W-1:0] STEP_MAX = STEP_W'(10);
  localparam logic signed [STEP_W-1:0] STEP_MIN = -STEP_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P  = 3'd0,
    CFG_GAIN_I  = 3'd1,
    CFG_GAIN_D  = 3'd2,
    CFG_PWM_MIN = 3'd3,
    CFG_PWM_MAX = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [DUTY_W-1:0] pwm_min;
    logic [DUTY_W-1:0] pwm_max;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic                    act;
    logic signed [PP_W-1:0]  p;
    logic signed [PI_W-1:0]  i;
    logic signed [PD_W-1:0]  d;
  } prod_t;

  typedef struct packed {
    logic                     valid;
    logic                     act;
    logic signed [STEP_W-1:0] step;
  } step_t;

endpackage
`default_nettype wire

// File: design/ipid_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Incremental PID speed loop - channel interfaces
// Valid/ready channels for speed samples and duty results.
// ----------------------------------------------------------------------------
interface ipid_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] target_speed;
  logic [15:0] measured_speed;

  modport source (output valid, output target_speed, output measured_speed, input ready);
  modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface ipid_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pwm_duty;
  logic        adjusted;

  modport source (output valid, output pwm_duty, output adjusted, input ready);
  modport sink   (input valid, input pwm_duty, input adjusted, output ready);
endinterface
`default_nettype wire

// File: design/ipid_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Incremental PID speed loop - configuration registers
// Gains and duty limits, written through a plain write port.
// ----------------------------------------------------------------------------
module ipid_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ipid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ipid_pkg::cfg_t                       cfg_o
);
  import ipid_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p  <= GAIN_P_RST;
      cfg_q.gain_i  <= GAIN_I_RST;
      cfg_q.gain_d  <= GAIN_D_RST;
      cfg_q.pwm_min <= PWM_MIN_RST;
      cfg_q.pwm_max <= PWM_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_P:  cfg_q.gain_p  <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I:  cfg_q.gain_i  <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D:  cfg_q.gain_d  <= cfg_data_i[GAIN_W-1:0];
        CFG_PWM_MIN: cfg_q.pwm_min <= cfg_data_i[DUTY_W-1:0];
        CFG_PWM_MAX: cfg_q.pwm_max <= cfg_data_i[DUTY_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: design/ipid_err.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Incremental PID speed loop - error stage
// Input register, error history and the three gain products.
// ----------------------------------------------------------------------------
module ipid_err (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,
  input  wire logic                         in_valid_i,
  input  wire logic [ipid_pkg::SPEED_W-1:0] target_i,
  input  wire logic [ipid_pkg::SPEED_W-1:0] measured_i,
  input  wire ipid_pkg::cfg_t               cfg_i,
  output ipid_pkg::prod_t                   prod_o
);
  import ipid_pkg::*;

  logic                    in_vld_q;
  logic [SPEED_W-1:0]      tgt_q;
  logic [SPEED_W-1:0]      meas_q;
  logic signed [ERR_W-1:0] last_err_q;
  logic signed [ERR_W-1:0] older_err_q;
  logic signed [ERR_W-1:0] err;
  logic signed [D1_W-1:0]  d1;
  logic signed [D2_W-1:0]  d2;
  logic                    act;
  prod_t                   prod_d;
  prod_t                   prod_q;

  always_comb begin
    err = $signed({1'b0, tgt_q}) - $signed({1'b0, meas_q});
    // deadband covers -1, 0 and +1
    act = (err > ERR_W'(1)) || (err < -ERR_W'(1));
    d1  = D1_W'(err) - D1_W'(last_err_q);
    d2  = D2_W'(err) + D2_W'(older_err_q) - (D2_W'(last_err_q) <<< 1);
    prod_d.valid = in_vld_q;
    prod_d.act   = act;
    prod_d.p     = $signed({1'b0, cfg_i.gain_p}) * d1;
    prod_d.i     = $signed({1'b0, cfg_i.gain_i}) * err;
    prod_d.d     = $signed({1'b0, cfg_i.gain_d}) * d2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      last_err_q  <= '0;
      older_err_q <= '0;
      prod_q      <= '0;
    end else if (adv_i) begin
      in_vld_q <= in_valid_i;
      prod_q   <= prod_d;
      if (in_vld_q && act) begin
        older_err_q <= last_err_q;
        last_err_q  <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tgt_q  <= target_i;
      meas_q <= measured_i;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// File: design/ipid_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Incremental PID speed loop - step stage
// Sum the products, scale toward zero and limit the step.
// ----------------------------------------------------------------------------
module ipid_step (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire ipid_pkg::prod_t prod_i,
  output ipid_pkg::step_t     step_o
);
  import ipid_pkg::*;

  localparam int unsigned QUO_W = SUM_W - Q_SHIFT;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_adj;
  logic signed [QUO_W-1:0] quo;
  step_t                   step_d;
  step_t                   step_q;

  always_comb begin
    sum = SUM_W'(prod_i.p) + SUM_W'(prod_i.i) + SUM_W'(prod_i.d);
    // bias negatives so the shift truncates toward zero
    sum_adj = sum[SUM_W-1] ? (sum + SUM_W'((1 << Q_SHIFT) - 1)) : sum;
    quo     = QUO_W'(sum_adj >>> Q_SHIFT);
    step_d.valid = prod_i.valid;
    step_d.act   = prod_i.act;
    if (!prod_i.act) begin
      step_d.step = '0;
    end else if (quo > QUO_W'(STEP_MAX)) begin
      step_d.step = STEP_MAX;
    end else if (quo < QUO_W'(STEP_MIN)) begin
      step_d.step = STEP_MIN;
    end else begin
      step_d.step = STEP_W'(quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (adv_i) begin
      step_q <= step_d;
    end
  end

  assign step_o = step_q;

endmodule
`default_nettype wire

// File: design/ipid_duty.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Incremental PID speed loop - duty stage
// Duty count state, limit clamp and the result register.
// ----------------------------------------------------------------------------
module ipid_duty (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        adv_i,
  input  wire ipid_pkg::step_t             step_i,
  input  wire ipid_pkg::cfg_t              cfg_i,
  output logic                             res_valid_o,
  output logic [ipid_pkg::DUTY_W-1:0]      res_duty_o,
  output logic                             res_adjusted_o
);
  import ipid_pkg::*;

  logic [DUTY_W-1:0]        duty_q;
  logic [DUTY_W-1:0]        duty_d;
  logic signed [DSUM_W-1:0] dsum;
  logic                     res_vld_q;
  logic [DUTY_W-1:0]        res_duty_q;
  logic                     res_adj_q;

  always_comb begin
    dsum = $signed({2'b00, duty_q}) + DSUM_W'(step_i.step);
    if (dsum < $signed({2'b00, cfg_i.pwm_min})) begin
      dsum = $signed({2'b00, cfg_i.pwm_min});
    end
    // upper limit applies last, so it wins when the limits cross
    if (dsum > $signed({2'b00, cfg_i.pwm_max})) begin
      dsum = $signed({2'b00, cfg_i.pwm_max});
    end
    duty_d = step_i.act ? dsum[DUTY_W-1:0] : duty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q    <= DUTY_RST;
      res_vld_q <= 1'b0;
      res_adj_q <= 1'b0;
    end else if (adv_i) begin
      res_vld_q <= step_i.valid;
      if (step_i.valid) begin
        duty_q    <= duty_d;
        res_adj_q <= step_i.act;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && step_i.valid) begin
      res_duty_q <= duty_d;
    end
  end

  assign res_valid_o    = res_vld_q;
  assign res_duty_o     = res_duty_q;
  assign res_adjusted_o = res_adj_q;

endmodule
`default_nettype wire

// File: design/incremental_pid_pwm_speed_loop_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Incremental PID speed loop - top level
// Error, incremental PID step and clamped PWM duty, one result per sample.
//
//  channel | dir | payload                          | transaction when
//  in_i    | in  | target_speed, measured_speed     | valid && ready
//  out_o   | out | pwm_duty, adjusted               | valid && ready
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i  | cfg_we_i high
//
// Four register stages: input, gain products, limited step, result. A
// transaction enters every cycle unless out_o is stalled. The three products
// in the second stage set the critical path.
// Reset clears the error history, loads the duty with half the period and
// the registers with their defaults. A stalled result holds the whole
// pipeline, so ready drops only while out_o is stalled.
// ----------------------------------------------------------------------------
module incremental_pid_pwm_speed_loop_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  ipid_in_if.sink                              in_i,
  ipid_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ipid_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ipid_pkg::*;

  cfg_t  cfg;
  prod_t prod_s;
  step_t step_s;
  logic  adv;

  // advance every stage together whenever the result slot is free or taken
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  ipid_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // latch the sample, form the error, shift history, multiply by the gains
  ipid_err u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_i.valid),
    .target_i   (in_i.target_speed),
    .measured_i (in_i.measured_speed),
    .cfg_i      (cfg),
    .prod_o     (prod_s)
  );

  // sum, scale the Q8.8 result toward zero and limit to the step range
  ipid_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .prod_i (prod_s),
    .step_o (step_s)
  );

  // apply the step to the duty and clamp between the limits
  ipid_duty u_duty (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .step_i         (step_s),
    .cfg_i          (cfg),
    .res_valid_o    (out_o.valid),
    .res_duty_o     (out_o.pwm_duty),
    .res_adjusted_o (out_o.adjusted)
  );

`ifndef SYNTH
  a_duty_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.adjusted && (cfg.pwm_min <= cfg.pwm_max)
    |-> (out_o.pwm_duty >= cfg.pwm_min) && (out_o.pwm_duty <= cfg.pwm_max))
    else $error("adjusted duty outside limits");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_s.valid |-> (step_s.step <= STEP_MAX) && (step_s.step >= STEP_MIN))
    else $error("step outside range");

  a_deadband_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_s.valid && !step_s.act |-> step_s.step == '0)
    else $error("non-zero step inside deadband");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_s.valid && adv |=> out_o.valid && (out_o.adjusted == $past(step_s.act)))
    else $error("result lost between step and output");
`endif

endmodule
`default_nettype wire

// File: test/incremental_pid_pwm_speed_loop_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Incremental PID speed loop - testbench
// Drives speed samples and register writes into the loop. A predictor of the
// error history, the limited Q8.8 step and the clamped duty runs next to it.
// Each result transaction is checked in order against the predicted duty and
// adjusted flag. Both channels idle at random.
// ----------------------------------------------------------------------------
module incremental_pid_pwm_speed_loop_unit_tb;
  import ipid_pkg::*;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_duty;
    logic              adjusted;
  } duty_result_t;

  localparam int unsigned SETTLE_CYC  = 6;   // pipeline depth plus margin
  localparam int unsigned ITEMS_PHASE = 370;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ipid_in_if  in_if ();
  ipid_out_if out_if ();

  incremental_pid_pwm_speed_loop_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor copy of the registers and of the loop state.
  logic [GAIN_W-1:0]       pred_gain_p, pred_gain_i, pred_gain_d;
  logic [DUTY_W-1:0]       pred_pwm_min, pred_pwm_max;
  logic [DUTY_W-1:0]       pred_duty;
  logic signed [ERR_W-1:0] pred_last_err, pred_older_err;

  duty_result_t duty_expect_q[$];
  int unsigned  mismatch_cnt;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  // 8 ns clock.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Generous fixed limit; a healthy run needs a small fraction of it.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side back-pressure: decide ready afresh at every falling edge.
  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void load_loop_reg(input logic [CFG_IDX_W-1:0]  idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GAIN_P:  pred_gain_p  = data[GAIN_W-1:0];
      CFG_GAIN_I:  pred_gain_i  = data[GAIN_W-1:0];
      CFG_GAIN_D:  pred_gain_d  = data[GAIN_W-1:0];
      CFG_PWM_MIN: pred_pwm_min = data[DUTY_W-1:0];
      CFG_PWM_MAX: pred_pwm_max = data[DUTY_W-1:0];
      default: ;  // spare indexes change nothing
    endcase
  endfunction

  // One sample through the loop: deadband test, incremental step, duty clamp.
  function automatic duty_result_t advance_speed_loop(input logic [SPEED_W-1:0] tgt,
                                                      input logic [SPEED_W-1:0] meas);
    longint       err, d1, d2, acc, stp, nxt;
    duty_result_t res;
    err = longint'(tgt) - longint'(meas);
    res.adjusted = (err > 1) || (err < -1);
    if (res.adjusted) begin
      d1  = err - longint'(pred_last_err);
      d2  = err + longint'(pred_older_err) - 2 * longint'(pred_last_err);
      acc = longint'(pred_gain_p) * d1 + longint'(pred_gain_i) * err
          + longint'(pred_gain_d) * d2;
      // Signed division truncates toward zero, as the Q8.8 step requires.
      stp = acc / (longint'(1) << Q_SHIFT);
      if (stp > longint'(STEP_MAX)) stp = longint'(STEP_MAX);
      if (stp < longint'(STEP_MIN)) stp = longint'(STEP_MIN);
      // Hold the duty signed here so a negative sum is raised, not wrapped.
      nxt = longint'(pred_duty) + stp;
      if (nxt < longint'(pred_pwm_min)) nxt = longint'(pred_pwm_min);
      if (nxt > longint'(pred_pwm_max)) nxt = longint'(pred_pwm_max);
      pred_duty      = nxt[DUTY_W-1:0];
      pred_older_err = pred_last_err;
      pred_last_err  = err[ERR_W-1:0];
    end
    res.pwm_duty = pred_duty;
    return res;
  endfunction

  function automatic void report_fail(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_cnt++;
  endfunction

  // Observe both channels at the rising edge: predict on each accepted
  // sample, then check each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    duty_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) load_loop_reg(cfg_idx_i, cfg_data_i);
      if (in_if.valid && in_if.ready) begin
        duty_expect_q.push_back(advance_speed_loop(in_if.target_speed,
                                                   in_if.measured_speed));
      end
      if (out_if.valid && out_if.ready) begin
        if (duty_expect_q.size() == 0) begin
          report_fail($sformatf("unexpected result: expected none, actual duty %0d adj %0b",
                                out_if.pwm_duty, out_if.adjusted));
        end else begin
          want = duty_expect_q.pop_front();
          if (out_if.pwm_duty !== want.pwm_duty)
            report_fail($sformatf("pwm_duty expected %0d actual %0d",
                                  want.pwm_duty, out_if.pwm_duty));
          if (out_if.adjusted !== want.adjusted)
            report_fail($sformatf("adjusted expected %0b actual %0b",
                                  want.adjusted, out_if.adjusted));
        end
      end
    end
  end

  // Present one sample and hold it until the transaction completes.
  task automatic send_sample(input logic [SPEED_W-1:0] tgt,
                             input logic [SPEED_W-1:0] meas);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid          = 1'b1;
    in_if.target_speed   = tgt;
    in_if.measured_speed = meas;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Drop valid, wait for every predicted result, then let the pipe settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (duty_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kd);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
  endtask

  task automatic write_limits(input logic [CFG_DATA_W-1:0] lo,
                              input logic [CFG_DATA_W-1:0] hi);
    write_reg(CFG_PWM_MIN, lo);
    write_reg(CFG_PWM_MAX, hi);
  endtask

  // Errors of zero and one either way stay in the deadband; two leaves it.
  task automatic test_deadband();
    send_sample(16'd1000, 16'd1000);
    send_sample(16'd1001, 16'd1000);
    send_sample(16'd1000, 16'd1001);
    send_sample(16'd0, 16'd0);
    send_sample(16'd65535, 16'd65535);
    send_sample(16'd1002, 16'd1000);
    send_sample(16'd1000, 16'd1002);
  endtask

  // Full-scale errors drive the step into both of its limits.
  task automatic test_step_limits();
    send_sample(16'd65535, 16'd0);
    send_sample(16'd0, 16'd65535);
    send_sample(16'd65535, 16'd0);
    send_sample(16'd0, 16'd1);
  endtask

  // Largest and zero gains, and writes to the spare indexes.
  task automatic test_gain_extremes();
    write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'd65535, 16'd0);
    send_sample(16'd0, 16'd65535);
    send_sample(16'd40000, 16'd39990);
    write_gains(16'd0, 16'd0, 16'd0);
    send_sample(16'd500, 16'd100);
    // Spare indexes must leave every register alone.
    for (int k = int'(CFG_PWM_MAX) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    end
    send_sample(16'd100, 16'd500);
  endtask

  // Negative steps from a duty near zero must be raised to the floor.
  task automatic test_duty_floor();
    write_gains(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST);
    // Upper data bits above the 12-bit limit registers are dropped.
    write_limits(16'hF000, 16'hF003);
    send_sample(16'd3000, 16'd0);
    send_sample(16'd0, 16'd3000);
    send_sample(16'd0, 16'd3000);
  endtask

  // Crossed and top-of-range limits: the upper clamp wins.
  task automatic test_crossed_limits();
    write_limits(16'd800, 16'd200);
    send_sample(16'd3000, 16'd0);
    send_sample(16'd0, 16'd3000);
    send_sample(16'd100, 16'd100);
    write_limits(16'd4095, 16'd4095);
    send_sample(16'd3000, 16'd0);
    send_sample(16'd0, 16'd3000);
  endtask

  task automatic program_random_loop();
    logic [GAIN_W-1:0] kp, ki, kd;
    kp = ($urandom_range(99) < 80) ? GAIN_W'($urandom_range(512)) : GAIN_W'($urandom);
    ki = ($urandom_range(99) < 80) ? GAIN_W'($urandom_range(128)) : GAIN_W'($urandom);
    kd = ($urandom_range(99) < 80) ? GAIN_W'($urandom_range(256)) : GAIN_W'($urandom);
    write_gains(kp, ki, kd);
    write_limits(CFG_DATA_W'($urandom_range(600)), CFG_DATA_W'($urandom_range(4095, 400)));
  endtask

  // Mostly small errors around the target so the step is not always
  // saturated; the rest are deadband samples and full-range noise.
  task automatic send_random_samples(input int unsigned count);
    logic [SPEED_W-1:0] tgt;
    int                 delta;
    int                 meas_val;
    int unsigned        sel;
    for (int unsigned n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      tgt = SPEED_W'($urandom);
      if (sel < 15) begin
        meas_val = int'($urandom_range(65535));
      end else begin
        if (sel < 30) delta = int'($urandom_range(2)) - 1;
        else          delta = int'($urandom_range(80)) - 40;
        meas_val = int'(tgt) - delta;
        if (meas_val < 0 || meas_val > 65535) meas_val = int'(tgt);
      end
      send_sample(tgt, SPEED_W'(meas_val));
    end
  endtask

  // Two settings per phase; the sender drains the loop between them.
  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    program_random_loop();
    send_random_samples(ITEMS_PHASE / 2);
    program_random_loop();
    send_random_samples(ITEMS_PHASE - ITEMS_PHASE / 2);
  endtask

  initial begin
    pred_gain_p    = GAIN_P_RST;
    pred_gain_i    = GAIN_I_RST;
    pred_gain_d    = GAIN_D_RST;
    pred_pwm_min   = PWM_MIN_RST;
    pred_pwm_max   = PWM_MAX_RST;
    pred_duty      = DUTY_RST;
    pred_last_err  = '0;
    pred_older_err = '0;
    mismatch_cnt   = 0;
    send_idle_pct  = 27;
    recv_idle_pct  = 83;

    // Hold every input at a known level through reset.
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_GAIN_P;
    cfg_data_i           = '0;
    in_if.valid          = 1'b0;
    in_if.target_speed   = '0;
    in_if.measured_speed = '0;
    out_if.ready         = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_deadband();
    test_step_limits();
    test_gain_extremes();
    test_duty_floor();
    test_crossed_limits();
    test_random_traffic(27, 83);
    test_random_traffic(83, 27);
    test_random_traffic(0, 0);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && duty_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
